// ===== rtl/tobt_pkg.sv =====
// ----------------------------------------------------------------------------
// tobt_pkg
// Shared types for the top-of-book tracker: controller states, read address
// select codes, and the command and status words between control and datapath.
// ----------------------------------------------------------------------------
package tobt_pkg;

  localparam int unsigned PRICE_W = 48;
  localparam int unsigned QTY_W   = 48;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_INS,
    ST_ISH_RD,
    ST_ISH_WR,
    ST_REM,
    ST_RSH_RD,
    ST_RSH_WR,
    ST_QBID,
    ST_QASK
  } state_t;

  // level memory read address select
  typedef enum logic [1:0] {
    RSEL_IDX,
    RSEL_JM1,
    RSEL_JP1
  } rsel_t;

  // controller to datapath
  typedef struct packed {
    logic  load;       // latch the input word, clear the scan index
    logic  rd;         // read the level memory
    rsel_t rsel;       // read address select
    logic  idx_inc;    // advance the scan index
    logic  ins_setup;  // set up the insert shift, grow count if room
    logic  rem_setup;  // set up the remove shift
    logic  j_dec;
    logic  j_inc;
    logic  wr_shift;   // write read data at j
    logic  wr_price;   // write the new price at the slot
    logic  cnt_dec;
    logic  emit_bid;
    logic  emit_ask;
    logic  quote_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_end;     // scan index reached the level count
    logic ahead;       // stored level ranks ahead of the new price
    logic equal;       // stored level equals the new price
    logic full;        // side holds the maximum number of levels
    logic remove;      // update removes a level
    logic eom;         // last update of the message
    logic ins_more;    // insert shift has levels left to move
    logic rem_more;    // remove shift has levels left to move
    logic bid_new;     // best bid present and not yet quoted
    logic ask_new;     // best ask present and not yet quoted
  } sts_t;

endpackage

// ===== rtl/tobt_ram.sv =====
// ----------------------------------------------------------------------------
// tobt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tobt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tobt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tobt_ctrl
// Sequencer for one level update: scan for the slot, shift levels to insert
// or remove, then at message end check and emit the bid and ask quotes.
// ----------------------------------------------------------------------------
module tobt_ctrl import tobt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.idx_end) begin
          // price ranks after every stored level
          if (sts.remove || sts.full) state_next = ST_QBID;
          else                        state_next = ST_INS;
        end else begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.ahead)       state_next = ST_SEARCH;
        else if (sts.equal)  state_next = sts.remove ? ST_REM : ST_QBID;
        else                 state_next = sts.remove ? ST_QBID : ST_INS;
      end
      ST_INS:    state_next = ST_ISH_RD;
      ST_ISH_RD: state_next = sts.ins_more ? ST_ISH_WR : ST_QBID;
      ST_ISH_WR: state_next = ST_ISH_RD;
      ST_REM:    state_next = ST_RSH_RD;
      ST_RSH_RD: state_next = sts.rem_more ? ST_RSH_WR : ST_QBID;
      ST_RSH_WR: state_next = ST_RSH_RD;
      ST_QBID:   state_next = sts.eom ? ST_QASK : ST_IDLE;
      ST_QASK:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.rsel = RSEL_IDX;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_SEARCH: begin
        cmd.rd = !sts.idx_end;
      end
      ST_CMP: begin
        cmd.idx_inc = sts.ahead;
      end
      ST_INS: begin
        cmd.ins_setup = 1'b1;
      end
      ST_ISH_RD: begin
        cmd.rd       = sts.ins_more;
        cmd.rsel     = RSEL_JM1;
        cmd.wr_price = !sts.ins_more;
      end
      ST_ISH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.j_dec    = 1'b1;
      end
      ST_REM: begin
        cmd.rem_setup = 1'b1;
      end
      ST_RSH_RD: begin
        cmd.rd      = sts.rem_more;
        cmd.rsel    = RSEL_JP1;
        cmd.cnt_dec = !sts.rem_more;
      end
      ST_RSH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.j_inc    = 1'b1;
      end
      ST_QBID: begin
        cmd.emit_bid   = sts.eom && sts.bid_new;
        cmd.quote_last = !sts.ask_new;
      end
      ST_QASK: begin
        cmd.emit_ask   = sts.ask_new;
        cmd.quote_last = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/tobt_dp.sv =====
// ----------------------------------------------------------------------------
// tobt_dp
// Datapath: sorted level memory for both sides, scan and shift indexes,
// level counts, best-level mirrors, last quoted prices and quote registers.
// ----------------------------------------------------------------------------
module tobt_dp import tobt_pkg::*; #(
  parameter int unsigned LEVELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               side,
  input  logic [PRICE_W-1:0] price,
  input  logic [QTY_W-1:0]   quantity,
  input  logic               end_of_message,
  input  logic               instrument_id_we,
  input  logic               instrument_id_wdata,
  output logic               quote_valid,
  output logic [PRICE_W-1:0] quote_price,
  output logic               quote_side,
  output logic               quote_instrument,
  output logic               last_of_run
);

  localparam int unsigned AW = $clog2(LEVELS);
  localparam int unsigned CW = $clog2(LEVELS + 1);

  // latched update word
  logic               side_r;
  logic [PRICE_W-1:0] price_r;
  logic               remove_r;
  logic               eom_r;

  logic [CW-1:0] idx;       // scan index, later the slot
  logic [CW-1:0] j;         // shift index
  logic [CW-1:0] bid_cnt;
  logic [CW-1:0] ask_cnt;
  logic [PRICE_W-1:0] best_bid;
  logic [PRICE_W-1:0] best_ask;
  logic [PRICE_W-1:0] quoted_bid;
  logic [PRICE_W-1:0] quoted_ask;
  logic               inst_id;

  logic [CW-1:0]      n_cur;
  logic [CW:0]        j_plus1;
  logic [CW-1:0]      raddr_idx;
  logic [CW-1:0]      waddr_idx;
  logic               we;
  logic [PRICE_W-1:0] wdata;
  logic [PRICE_W-1:0] rdata;

  assign n_cur   = side_r ? bid_cnt : ask_cnt;
  assign j_plus1 = {1'b0, j} + (CW+1)'(1);

  // read address select
  always_comb begin
    case (cmd.rsel)
      RSEL_IDX: raddr_idx = idx;
      RSEL_JM1: raddr_idx = j - CW'(1);
      RSEL_JP1: raddr_idx = j_plus1[CW-1:0];
      default:  raddr_idx = idx;
    endcase
  end

  // write port
  assign we        = cmd.wr_shift || cmd.wr_price;
  assign waddr_idx = cmd.wr_price ? idx : j;
  assign wdata     = cmd.wr_price ? price_r : rdata;

  // both sides share one memory, side bit on top of the address
  tobt_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (2 * (1 << AW))
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr ({side_r, waddr_idx[AW-1:0]}),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr ({side_r, raddr_idx[AW-1:0]}),
    .rdata (rdata)
  );

  // status
  always_comb begin
    sts          = '0;
    sts.idx_end  = (idx >= n_cur);
    sts.ahead    = side_r ? (rdata > price_r) : (rdata < price_r);
    sts.equal    = (rdata == price_r);
    sts.full     = (n_cur == CW'(LEVELS));
    sts.remove   = remove_r;
    sts.eom      = eom_r;
    sts.ins_more = (j > idx);
    sts.rem_more = (j_plus1 < {1'b0, n_cur});
    sts.bid_new  = (bid_cnt != '0) && (best_bid != quoted_bid);
    sts.ask_new  = (ask_cnt != '0) && (best_ask != quoted_ask);
  end

  // update word and indexes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      side_r   <= side;
      price_r  <= price;
      remove_r <= (quantity == '0);
      eom_r    <= end_of_message;
      idx      <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (cmd.ins_setup) begin
      j <= sts.full ? CW'(LEVELS - 1) : n_cur;
    end else if (cmd.rem_setup) begin
      j <= idx;
    end else if (cmd.j_dec) begin
      j <= j - CW'(1);
    end else if (cmd.j_inc) begin
      j <= j_plus1[CW-1:0];
    end
  end

  // level counts
  always_ff @(posedge clk) begin
    if (rst) begin
      bid_cnt <= '0;
      ask_cnt <= '0;
    end else if (cmd.ins_setup && !sts.full) begin
      if (side_r) bid_cnt <= bid_cnt + CW'(1);
      else        ask_cnt <= ask_cnt + CW'(1);
    end else if (cmd.cnt_dec) begin
      if (side_r) bid_cnt <= bid_cnt - CW'(1);
      else        ask_cnt <= ask_cnt - CW'(1);
    end
  end

  // mirror of entry zero on each side
  always_ff @(posedge clk) begin
    if (we && (waddr_idx == '0)) begin
      if (side_r) best_bid <= wdata;
      else        best_ask <= wdata;
    end
  end

  // last quoted prices and instrument register
  always_ff @(posedge clk) begin
    if (rst) begin
      quoted_bid <= '0;
      quoted_ask <= '0;
      inst_id    <= 1'b0;
    end else begin
      if (cmd.emit_bid) quoted_bid <= best_bid;
      if (cmd.emit_ask) quoted_ask <= best_ask;
      if (instrument_id_we) inst_id <= instrument_id_wdata;
    end
  end

  // quote output word
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_valid <= 1'b0;
    end else begin
      quote_valid <= cmd.emit_bid || cmd.emit_ask;
    end
    quote_price      <= cmd.emit_bid ? best_bid : best_ask;
    quote_side       <= cmd.emit_bid;
    quote_instrument <= inst_id;
    last_of_run      <= cmd.quote_last;
  end

endmodule

// ===== rtl/top_of_book_tracker_core.sv =====
// ----------------------------------------------------------------------------
// top_of_book_tracker_core
// Best bid / best ask tracker over two sorted sets of price levels.
//
//   channel   ports                                        handshake
//   update    side, price, quantity, end_of_message        start, busy
//   quote     quote_price, quote_side, quote_instrument,   quote_valid
//             last_of_run
//   config    instrument_id_wdata                          instrument_id_we
//
// One update word at a time. The slot scan reads and then compares each
// stored level in turn, and each level moved by an insert or remove takes a
// read and then a write of the level memory; the quote check follows.
// Scan and shift together span one side. Quotes leave one per cycle after
// the last update of a message, bid first. Reset empties both sides and
// clears the last quoted prices. Quotes cannot be held off; busy stays high
// until the quote check is done.
// ----------------------------------------------------------------------------
module top_of_book_tracker_core import tobt_pkg::*; #(
  parameter int unsigned LEVELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               side,
  input  logic [PRICE_W-1:0] price,
  input  logic [QTY_W-1:0]   quantity,
  input  logic               end_of_message,
  input  logic               instrument_id_we,
  input  logic               instrument_id_wdata,
  output logic               quote_valid,
  output logic [PRICE_W-1:0] quote_price,
  output logic               quote_side,
  output logic               quote_instrument,
  output logic               last_of_run
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tobt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // levels and quotes
  tobt_dp #(
    .LEVELS (LEVELS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .side                (side),
    .price               (price),
    .quantity            (quantity),
    .end_of_message      (end_of_message),
    .instrument_id_we    (instrument_id_we),
    .instrument_id_wdata (instrument_id_wdata),
    .quote_valid         (quote_valid),
    .quote_price         (quote_price),
    .quote_side          (quote_side),
    .quote_instrument    (quote_instrument),
    .last_of_run         (last_of_run)
  );

  // an accepted update keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after accepted update");

  // a quote that is not last is a bid, followed at once by the closing ask
  a_bid_then_ask: assert property (@(posedge clk) disable iff (rst)
    quote_valid && !last_of_run |=> quote_valid && last_of_run && !quote_side)
    else $error("bid quote not followed by ask quote");

  a_first_is_bid: assert property (@(posedge clk) disable iff (rst)
    quote_valid && !last_of_run |-> quote_side)
    else $error("non-final quote is not a bid");

  // shift write never shares a cycle with the price write or a read
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shift |-> !cmd.wr_price && !cmd.rd)
    else $error("level memory write conflict");

endmodule
